[src/weighted_adjacency_matrix_store_defines.svh]
`ifndef WEIGHTED_ADJACENCY_MATRIX_STORE_DEFINES_SVH
`define WEIGHTED_ADJACENCY_MATRIX_STORE_DEFINES_SVH
// Assertion macros for the adjacency matrix store checks.

// The consequent must hold in the same cycle as the antecedent.
`define WAMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WAMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wams_pkg.sv]
// Shared types, codes and microprogram for the adjacency matrix store.
`timescale 1ns / 1ps
package wams_pkg;

  // Weight pattern that marks a missing edge (IEEE +infinity).
  localparam logic [63:0] NO_EDGE = 64'h7FF0_0000_0000_0000;

  localparam int UPC_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED = 1'd1;

  // Action codes.
  localparam logic [2:0] ACT_ADD        = 3'd0;
  localparam logic [2:0] ACT_REMOVE     = 3'd1;
  localparam logic [2:0] ACT_READ       = 3'd2;
  localparam logic [2:0] ACT_TRANSPOSE  = 3'd3;
  localparam logic [2:0] ACT_SCAN_START = 3'd4;
  localparam logic [2:0] ACT_SCAN_STEP  = 3'd5;

  // Microprogram step addresses.
  localparam logic [UPC_W-1:0] ST_CLR  = 5'd0;
  localparam logic [UPC_W-1:0] ST_IDLE = 5'd1;
  localparam logic [UPC_W-1:0] ST_FIN  = 5'd2;
  localparam logic [UPC_W-1:0] ST_AD0  = 5'd3;
  localparam logic [UPC_W-1:0] ST_AD1  = 5'd4;
  localparam logic [UPC_W-1:0] ST_AD2  = 5'd5;
  localparam logic [UPC_W-1:0] ST_RD0  = 5'd6;
  localparam logic [UPC_W-1:0] ST_RD1  = 5'd7;
  localparam logic [UPC_W-1:0] ST_T0   = 5'd8;
  localparam logic [UPC_W-1:0] ST_TI   = 5'd9;
  localparam logic [UPC_W-1:0] ST_TJ   = 5'd10;
  localparam logic [UPC_W-1:0] ST_T1   = 5'd11;
  localparam logic [UPC_W-1:0] ST_T2   = 5'd12;
  localparam logic [UPC_W-1:0] ST_T3   = 5'd13;
  localparam logic [UPC_W-1:0] ST_TNI  = 5'd14;
  localparam logic [UPC_W-1:0] ST_SC0  = 5'd15;
  localparam logic [UPC_W-1:0] ST_SC1  = 5'd16;
  localparam logic [UPC_W-1:0] ST_SCX  = 5'd17;
  localparam logic [UPC_W-1:0] ST_SS0  = 5'd18;
  localparam logic [UPC_W-1:0] ST_SS1  = 5'd19;
  localparam logic [UPC_W-1:0] ST_SA0  = 5'd20;
  localparam logic [UPC_W-1:0] ST_SA1  = 5'd21;
  localparam logic [UPC_W-1:0] ST_SA2  = 5'd22;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  src_vertex;
    logic [7:0]  dst_vertex;
    logic [63:0] weight_in;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [63:0] weight_out;
    logic        scan_valid;
    logic [3:0]  scan_row;
    logic [4:0]  scan_column;
  } out_t;

  typedef enum logic [2:0] {
    A_SD, A_DS, A_IJ, A_JI, A_SCAN, A_CLR
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_ADD, WD_RD, WD_TMP, WD_NOEDGE
  } wd_sel_t;

  typedef enum logic [1:0] {
    I_HOLD, I_CLR, I_INC
  } i_op_t;

  typedef enum logic [1:0] {
    J_HOLD, J_LOAD, J_INC
  } j_op_t;

  typedef enum logic [1:0] {
    SC_HOLD, SC_START, SC_KILL, SC_INC
  } scan_op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOT_RANGE, C_DIRECTED, C_UNDIRECTED, C_S_OUT,
    C_I_DONE, C_J_DONE, C_SCAN_DONE, C_EDGE, C_CLR_MORE
  } cond_t;

  // One microprogram control word.
  typedef struct packed {
    addr_sel_t         addr_sel;
    logic              wr_en;
    wd_sel_t           wd_sel;
    logic              wout_ld;
    logic              tmp_ld;
    i_op_t             i_op;
    j_op_t             j_op;
    scan_op_t          scan_op;
    logic              clr_inc;
    logic              done;
    logic              dispatch;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } ctrl_t;

  // Datapath conditions tested by the sequencer.
  typedef struct packed {
    logic not_range;
    logic directed;
    logic s_out;
    logic i_done;
    logic j_done;
    logic scan_done;
    logic is_edge;
    logic clr_more;
  } flags_t;

  // Microprogram ROM. A taken condition jumps to target, else the step counter advances.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      ST_CLR: begin
        w.addr_sel = A_CLR; w.wr_en = 1'b1; w.wd_sel = WD_NOEDGE;
        w.clr_inc = 1'b1; w.cond = C_CLR_MORE; w.target = ST_CLR;
      end
      ST_IDLE: w.dispatch = 1'b1;
      ST_FIN: begin
        w.done = 1'b1; w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
      // Add or remove: the entry, then its mirror when undirected.
      ST_AD0: begin
        w.cond = C_NOT_RANGE; w.target = ST_FIN;
      end
      ST_AD1: begin
        w.addr_sel = A_SD; w.wr_en = 1'b1; w.wd_sel = WD_ADD;
        w.cond = C_DIRECTED; w.target = ST_FIN;
      end
      ST_AD2: begin
        w.addr_sel = A_DS; w.wr_en = 1'b1; w.wd_sel = WD_ADD;
        w.cond = C_ALWAYS; w.target = ST_FIN;
      end
      // Read one entry.
      ST_RD0: begin
        w.addr_sel = A_SD; w.cond = C_NOT_RANGE; w.target = ST_FIN;
      end
      ST_RD1: begin
        w.wout_ld = 1'b1; w.cond = C_ALWAYS; w.target = ST_FIN;
      end
      // Transpose, directed only: swap (i,j) and (j,i) over the upper triangle.
      ST_T0: begin
        w.i_op = I_CLR; w.cond = C_UNDIRECTED; w.target = ST_FIN;
      end
      ST_TI: begin
        w.j_op = J_LOAD; w.cond = C_I_DONE; w.target = ST_FIN;
      end
      ST_TJ: begin
        w.addr_sel = A_IJ; w.cond = C_J_DONE; w.target = ST_TNI;
      end
      ST_T1: begin
        w.addr_sel = A_JI; w.tmp_ld = 1'b1;
      end
      ST_T2: begin
        w.addr_sel = A_IJ; w.wr_en = 1'b1; w.wd_sel = WD_RD;
      end
      ST_T3: begin
        w.addr_sel = A_JI; w.wr_en = 1'b1; w.wd_sel = WD_TMP;
        w.j_op = J_INC; w.cond = C_ALWAYS; w.target = ST_TJ;
      end
      ST_TNI: begin
        w.i_op = I_INC; w.cond = C_ALWAYS; w.target = ST_TI;
      end
      // Scan start.
      ST_SC0: begin
        w.cond = C_S_OUT; w.target = ST_SCX;
      end
      ST_SC1: begin
        w.scan_op = SC_START; w.cond = C_ALWAYS; w.target = ST_SA0;
      end
      ST_SCX: begin
        w.scan_op = SC_KILL; w.cond = C_ALWAYS; w.target = ST_FIN;
      end
      // Scan step.
      ST_SS0: begin
        w.cond = C_SCAN_DONE; w.target = ST_FIN;
      end
      ST_SS1: w.scan_op = SC_INC;
      // Advance the cursor to the next entry that holds an edge.
      ST_SA0: begin
        w.addr_sel = A_SCAN; w.cond = C_SCAN_DONE; w.target = ST_FIN;
      end
      ST_SA1: begin
        w.wout_ld = 1'b1; w.cond = C_EDGE; w.target = ST_FIN;
      end
      ST_SA2: begin
        w.scan_op = SC_INC; w.cond = C_ALWAYS; w.target = ST_SA0;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // First step of each action's routine.
  function automatic logic [UPC_W-1:0] entry_step(input logic [2:0] action);
    logic [UPC_W-1:0] s;
    case (action)
      ACT_ADD, ACT_REMOVE: s = ST_AD0;
      ACT_READ:            s = ST_RD0;
      ACT_TRANSPOSE:       s = ST_T0;
      ACT_SCAN_START:      s = ST_SC0;
      ACT_SCAN_STEP:       s = ST_SS0;
      default:             s = ST_FIN;
    endcase
    return s;
  endfunction

endpackage

[src/wams_seq.sv]
// Microprogram sequencer: step counter, control ROM, condition jumps and dispatch.
`timescale 1ns / 1ps
module wams_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2:0]             action,
  input  wams_pkg::flags_t       flags,
  output wams_pkg::ctrl_t        ctrl,
  output logic                   busy,
  output logic                   accept
);
  import wams_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             cond_hit;

  // Control word of the current step.
  assign ctrl   = ucode(upc_r);
  assign busy   = (upc_r != ST_IDLE);
  assign accept = start && !busy;

  // Condition select.
  always_comb begin
    case (ctrl.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NOT_RANGE:  cond_hit = flags.not_range;
      C_DIRECTED:   cond_hit = flags.directed;
      C_UNDIRECTED: cond_hit = !flags.directed;
      C_S_OUT:      cond_hit = flags.s_out;
      C_I_DONE:     cond_hit = flags.i_done;
      C_J_DONE:     cond_hit = flags.j_done;
      C_SCAN_DONE:  cond_hit = flags.scan_done;
      C_EDGE:       cond_hit = flags.is_edge;
      C_CLR_MORE:   cond_hit = flags.clr_more;
      default:      cond_hit = 1'b0;
    endcase
  end

  // Next step: dispatch from idle, a taken jump, or the following step.
  always_comb begin
    upc_nxt = upc_r + 1'b1;
    if (ctrl.dispatch) begin
      upc_nxt = start ? entry_step(action) : upc_r;
    end else if (cond_hit) begin
      upc_nxt = ctrl.target;
    end
  end

  // Reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[src/wams_dp.sv]
// Datapath: weight memory, loop and scan counters, configuration and result registers.
`timescale 1ns / 1ps
module wams_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wams_pkg::ctrl_t                  ctrl,
  input  logic                             accept,
  input  wams_pkg::in_t                    in_data,
  input  logic                             cfg_we,
  input  logic [wams_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wams_pkg::CFG_W-1:0]       cfg_wdata,
  output wams_pkg::flags_t                 flags,
  output logic                             out_valid,
  output wams_pkg::out_t                   out_data
);
  import wams_pkg::*;

  localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [63:0]       mem [DEPTH];
  logic [ADDR_W-1:0] mem_addr;
  logic [63:0]       wr_data;
  logic [63:0]       rd_data_r;

  logic [4:0]        vcnt_r;
  logic              dir_r;
  logic [2:0]        act_r;
  logic [7:0]        src_r;
  logic [7:0]        dst_r;
  logic [63:0]       win_r;
  logic [63:0]       wout_r;
  logic [63:0]       tmp_r;
  logic [4:0]        i_r;
  logic [4:0]        j_r;
  logic [4:0]        row_r;
  logic [4:0]        cur_r;
  logic [4:0]        size_r;
  logic [ADDR_W-1:0] clr_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [4:0]        n_cnt;
  logic              in_range;
  logic              scan_ok;
  logic              status;

  // Flat position of entry (r, c).
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(c);
  endfunction

  // Vertices in use, saturated at the matrix size.
  always_comb begin
    if (int'(vcnt_r) > MAX_VERTICES) begin
      n_cnt = 5'(MAX_VERTICES);
    end else begin
      n_cnt = vcnt_r;
    end
  end

  assign in_range = (src_r < {3'b000, n_cnt}) && (dst_r < {3'b000, n_cnt});
  assign scan_ok  = (cur_r < size_r);
  assign status   = (act_r inside {ACT_ADD, ACT_REMOVE}) && !in_range;

  // Conditions for the sequencer.
  assign flags.not_range = !in_range;
  assign flags.directed  = dir_r;
  assign flags.s_out     = !(src_r < {3'b000, n_cnt});
  assign flags.i_done    = (i_r >= n_cnt);
  assign flags.j_done    = (j_r >= n_cnt);
  assign flags.scan_done = !scan_ok;
  assign flags.is_edge   = (rd_data_r != NO_EDGE);
  assign flags.clr_more  = (clr_r != ADDR_W'(DEPTH - 1));

  // Memory address select.
  always_comb begin
    case (ctrl.addr_sel)
      A_SD:    mem_addr = cell_addr(src_r, dst_r);
      A_DS:    mem_addr = cell_addr(dst_r, src_r);
      A_IJ:    mem_addr = cell_addr(8'(i_r), 8'(j_r));
      A_JI:    mem_addr = cell_addr(8'(j_r), 8'(i_r));
      A_SCAN:  mem_addr = cell_addr(8'(row_r), 8'(cur_r));
      A_CLR:   mem_addr = clr_r;
      default: mem_addr = clr_r;
    endcase
  end

  // Memory write data select.
  always_comb begin
    case (ctrl.wd_sel)
      WD_ADD:    wr_data = (act_r == ACT_ADD) ? win_r : NO_EDGE;
      WD_RD:     wr_data = rd_data_r;
      WD_TMP:    wr_data = tmp_r;
      WD_NOEDGE: wr_data = NO_EDGE;
      default:   wr_data = NO_EDGE;
    endcase
  end

  // Weight memory with registered read.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[mem_addr] <= wr_data;
    end
    rd_data_r <= mem[mem_addr];
  end

  // Request latch and working registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_data.action;
      src_r  <= in_data.src_vertex;
      dst_r  <= in_data.dst_vertex;
      win_r  <= in_data.weight_in;
      wout_r <= NO_EDGE;
    end else if (ctrl.wout_ld) begin
      wout_r <= rd_data_r;
    end
    if (ctrl.tmp_ld) begin
      tmp_r <= rd_data_r;
    end
    if (ctrl.done) begin
      out_data_r.status      <= status;
      out_data_r.weight_out  <= wout_r;
      out_data_r.scan_valid  <= scan_ok;
      out_data_r.scan_row    <= scan_ok ? row_r[3:0] : 4'd0;
      out_data_r.scan_column <= scan_ok ? cur_r : size_r;
    end
  end

  // Configuration, loop counters, scan state and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= 5'd16;
      dir_r       <= 1'b1;
      i_r         <= '0;
      j_r         <= '0;
      row_r       <= '0;
      cur_r       <= '0;
      size_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VCOUNT:   vcnt_r <= cfg_wdata;
          CFG_DIRECTED: dir_r  <= cfg_wdata[0];
          default:      ;
        endcase
      end
      case (ctrl.i_op)
        I_CLR:   i_r <= '0;
        I_INC:   i_r <= i_r + 1'b1;
        default: ;
      endcase
      case (ctrl.j_op)
        J_LOAD:  j_r <= i_r + 1'b1;
        J_INC:   j_r <= j_r + 1'b1;
        default: ;
      endcase
      case (ctrl.scan_op)
        SC_START: begin
          row_r  <= src_r[4:0];
          size_r <= n_cnt;
          cur_r  <= '0;
        end
        SC_KILL: begin
          size_r <= '0;
          cur_r  <= '0;
        end
        SC_INC:  cur_r <= cur_r + 1'b1;
        default: ;
      endcase
      if (ctrl.clr_inc) begin
        clr_r <= clr_r + 1'b1;
      end
      out_valid_r <= ctrl.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/weighted_adjacency_matrix_store.sv]
// Top level of the weighted adjacency matrix store.
`timescale 1ns / 1ps
// Usage:
//   A request is taken at a rising edge where start is high and busy is low; its
//   fields arrive on in_data. Exactly one result follows: out_valid is high for
//   one cycle with out_data, and the receiver cannot stall it.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while the block is idle:
//   index 0 is the vertex count, index 1 the directed flag.
// Processing:
//   add, remove and read first check both vertices against the vertex count;
//   transpose swaps pairs only when directed; scan start stops early when the row is
//   out of range and scan step when the scan is over; otherwise either passes over
//   empty columns until it finds an edge or the row runs out.
//   One request is in work at a time; the microprogram sequencer steps through each
//   routine, and the single port weight memory allows one access per step.
// Reset: the memory is swept to the no-edge pattern, one entry per cycle, over all
//   MAX_VERTICES*MAX_VERTICES entries; busy stays high until it ends, while
//   configuration writes are taken as usual.
module weighted_adjacency_matrix_store #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  wams_pkg::in_t                   in_data,
  input  logic                            cfg_we,
  input  logic [wams_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wams_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output wams_pkg::out_t                  out_data
);
  import wams_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  // Sequencer.
  wams_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .flags  (flags),
    .ctrl   (ctrl),
    .busy   (busy),
    .accept (accept)
  );

  // Datapath and memory.
  wams_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[src/wams_checker.sv]
// Port-level checks for the adjacency matrix store and their bind.
`timescale 1ns / 1ps
`include "weighted_adjacency_matrix_store_defines.svh"
module wams_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input wams_pkg::out_t out_data
);
  import wams_pkg::*;

  // A taken request always occupies the block.
  `WAMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but block not busy")

  // A result is shown once the sequencer is back in idle.
  `WAMS_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while busy")

  // Results of two requests never come in adjacent cycles.
  `WAMS_ASSERT_NEXT(a_result_gap, out_valid, !out_valid, "results in adjacent cycles")

  // An invalid scan reports row zero.
  `WAMS_ASSERT_SAME(a_scan_row, out_valid && !out_data.scan_valid,
                    out_data.scan_row == 4'd0, "invalid scan with nonzero row")

endmodule

bind weighted_adjacency_matrix_store wams_checker u_wams_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[test/tb_weighted_adjacency_matrix_store.sv]
// Self-checking testbench for the weighted adjacency matrix store.
`timescale 1ns / 1ps
module tb_weighted_adjacency_matrix_store;
  import wams_pkg::*;

  localparam int MAXV = 16;
  localparam logic [2:0] ACT_NOP6 = 3'd6;
  localparam logic [2:0] ACT_NOP7 = 3'd7;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] W_A = 64'h0123_4567_89AB_CDEF;
  localparam int unsigned ITEMS_PER_SETTING = 305;
  localparam int unsigned MAX_PRINTED = 200;

  // One row of the directed plan: a register write or a request.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_t                  req;
    logic                 pinned;
    out_t                 result;
  } step_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic out_valid;
  out_t out_data;

  // Shadow copy of the matrix, the scan and the registers.
  logic [63:0] edge_weight [MAXV*MAXV];
  logic [3:0]  scan_row_q;
  logic [4:0]  scan_pos;
  logic [4:0]  scan_len;
  logic [4:0]  vcount_cfg;
  logic        directed_cfg;

  out_t        pending_results[$];
  int unsigned mismatch_count;

  // A result typed in by hand replaces the computed one for the next request.
  logic        pin_valid;
  out_t        pin_result;

  step_t plan[$];
  logic [4:0]  seg_vcount [6] = '{5'd16, 5'd16, 5'd1, 5'd9, 5'd31, 5'd12};
  logic        seg_dir [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int unsigned seg_idle [6] = '{23, 23, 84, 84, 0, 0};

  weighted_adjacency_matrix_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Move the scan cursor forward to the next column that holds an edge.
  function automatic void skip_empty();
    while (scan_pos < scan_len && edge_weight[{scan_row_q, scan_pos[3:0]}] == NO_EDGE)
      scan_pos++;
  endfunction

  // Apply one request to the shadow state and return the result it gives.
  function automatic out_t apply_request(input in_t req);
    out_t        r;
    int unsigned n;
    logic        in_range;
    logic [63:0] t;
    int          i;
    int          j;
    n = (vcount_cfg > 5'd16) ? MAXV : 32'(vcount_cfg);
    in_range = (32'(req.src_vertex) < n) && (32'(req.dst_vertex) < n);
    r = '0;
    r.weight_out = NO_EDGE;
    case (req.action)
      ACT_ADD, ACT_REMOVE: begin
        if (!in_range) begin
          r.status = 1'b1;
        end else begin
          t = (req.action == ACT_ADD) ? req.weight_in : NO_EDGE;
          edge_weight[{req.src_vertex[3:0], req.dst_vertex[3:0]}] = t;
          if (!directed_cfg)
            edge_weight[{req.dst_vertex[3:0], req.src_vertex[3:0]}] = t;
        end
      end
      ACT_READ: begin
        if (in_range)
          r.weight_out = edge_weight[{req.src_vertex[3:0], req.dst_vertex[3:0]}];
      end
      ACT_TRANSPOSE: begin
        if (directed_cfg) begin
          for (i = 0; i < int'(n); i++) begin
            for (j = i + 1; j < int'(n); j++) begin
              t = edge_weight[8'(i * MAXV + j)];
              edge_weight[8'(i * MAXV + j)] = edge_weight[8'(j * MAXV + i)];
              edge_weight[8'(j * MAXV + i)] = t;
            end
          end
        end
      end
      ACT_SCAN_START: begin
        // An out-of-range row kills the scan but keeps the old row.
        if (32'(req.src_vertex) >= n) begin
          scan_pos = '0;
          scan_len = '0;
        end else begin
          scan_row_q = req.src_vertex[3:0];
          scan_len = 5'(n);
          scan_pos = '0;
          skip_empty();
        end
        if (scan_pos < scan_len)
          r.weight_out = edge_weight[{scan_row_q, scan_pos[3:0]}];
      end
      ACT_SCAN_STEP: begin
        if (scan_pos < scan_len) begin
          scan_pos++;
          skip_empty();
        end
        if (scan_pos < scan_len)
          r.weight_out = edge_weight[{scan_row_q, scan_pos[3:0]}];
      end
      default: begin
      end
    endcase
    // The scan fields always show the scan state after the request.
    if (scan_pos < scan_len) begin
      r.scan_valid = 1'b1;
      r.scan_row = scan_row_q;
      r.scan_column = scan_pos;
    end else begin
      r.scan_column = scan_len;
    end
    return r;
  endfunction

  function automatic out_t outcome(input logic st, input logic [63:0] w, input logic v,
                                   input logic [3:0] row, input logic [4:0] col);
    return {st, w, v, row, col};
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t req_row(input logic [2:0] act, input logic [7:0] src,
                                    input logic [7:0] dst, input logic [63:0] w,
                                    input logic pin, input out_t res);
    step_t s;
    s = '0;
    s.req.action = act;
    s.req.src_vertex = src;
    s.req.dst_vertex = dst;
    s.req.weight_in = w;
    s.pinned = pin;
    s.result = res;
    return s;
  endfunction

  // Mostly in-range vertices, some on the boundary, a few anywhere in the field.
  function automatic logic [7:0] pick_vertex(input int unsigned n);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 88 && n > 0)
      return 8'($urandom_range(n - 1));
    else if (p < 94)
      return 8'(n);
    return 8'($urandom_range(255));
  endfunction

  function automatic in_t random_request();
    in_t         r;
    int unsigned n;
    int unsigned p;
    n = (vcount_cfg > 5'd16) ? MAXV : 32'(vcount_cfg);
    p = $urandom_range(99);
    if (p < 22)      r.action = ACT_ADD;
    else if (p < 32) r.action = ACT_REMOVE;
    else if (p < 54) r.action = ACT_READ;
    else if (p < 57) r.action = ACT_TRANSPOSE;
    else if (p < 69) r.action = ACT_SCAN_START;
    else if (p < 94) r.action = ACT_SCAN_STEP;
    else if (p < 97) r.action = ACT_NOP6;
    else             r.action = ACT_NOP7;
    r.src_vertex = pick_vertex(n);
    r.dst_vertex = pick_vertex(n);
    p = $urandom_range(99);
    if (p < 8)       r.weight_in = NO_EDGE;
    else if (p < 12) r.weight_in = '0;
    else if (p < 16) r.weight_in = ALL_ONES;
    else             r.weight_in = {$urandom, $urandom};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch in %s: got %h, expected %h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  // Present one request and hold it until the block takes it.
  task automatic issue(input in_t req, input logic pin, input out_t res);
    @(negedge clk);
    start = 1'b1;
    in_data = req;
    pin_valid = pin;
    pin_result = res;
    do @(posedge clk); while (busy);
  endtask

  // Sender gap of a random length, with junk on the data lines.
  task automatic hold_off(input int unsigned pct);
    int unsigned gap;
    logic [95:0] junk;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < pct) begin
      @(negedge clk);
      junk = {$urandom, $urandom, $urandom};
      start = 1'b0;
      in_data = in_t'(junk[$bits(in_t)-1:0]);
      gap++;
    end
  endtask

  // Stop sending until every request is answered and the block is idle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Check results, track register writes and predict each accepted request.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested result", out_data.weight_out, NO_EDGE);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.weight_out !== want.weight_out)
            report_mismatch("weight_out", out_data.weight_out, want.weight_out);
          if (out_data.scan_valid !== want.scan_valid)
            report_mismatch("scan_valid", 64'(out_data.scan_valid), 64'(want.scan_valid));
          if (out_data.scan_row !== want.scan_row)
            report_mismatch("scan_row", 64'(out_data.scan_row), 64'(want.scan_row));
          if (out_data.scan_column !== want.scan_column)
            report_mismatch("scan_column", 64'(out_data.scan_column), 64'(want.scan_column));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_VCOUNT:   vcount_cfg = cfg_wdata;
          CFG_DIRECTED: directed_cfg = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        want = apply_request(in_data);
        pending_results.push_back(pin_valid ? pin_result : want);
      end
    end
  end

  // Guard against a hung block.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          k;
    int unsigned seg;
    int unsigned waited;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pin_valid = 1'b0;
    pin_result = '0;
    mismatch_count = 0;
    for (k = 0; k < MAXV * MAXV; k++) edge_weight[8'(k)] = NO_EDGE;
    scan_row_q = '0;
    scan_pos = '0;
    scan_len = '0;
    vcount_cfg = 5'd16;
    directed_cfg = 1'b1;

    // Directed plan: reset contents, field extremes, every action, corner cases.
    plan.push_back(req_row(ACT_READ, 8'd0, 8'd0, '0, 1'b1, outcome(0, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_ADD, 8'd0, 8'd0, '0, 1'b1, outcome(0, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_ADD, 8'd15, 8'd15, ALL_ONES, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_ADD, 8'd16, 8'd0, W_A, 1'b1, outcome(1, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_REMOVE, 8'd0, 8'd255, '0, 1'b1,
                           outcome(1, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_READ, 8'd255, 8'd255, '0, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_READ, 8'd0, 8'd0, '0, 1'b1, outcome(0, '0, 0, 0, 0)));
    plan.push_back(req_row(ACT_READ, 8'd15, 8'd15, '0, 1'b1, outcome(0, ALL_ONES, 0, 0, 0)));
    // An edge in column zero stops the scan right at its start.
    plan.push_back(req_row(ACT_SCAN_START, 8'd0, 8'd0, '0, 1'b1, outcome(0, '0, 1, 0, 0)));
    plan.push_back(req_row(ACT_SCAN_STEP, 8'd0, 8'd0, '0, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 16)));
    plan.push_back(req_row(ACT_ADD, 8'd3, 8'd7, W_A, 1'b0, '0));
    plan.push_back(req_row(ACT_TRANSPOSE, 8'd0, 8'd0, '0, 1'b0, '0));
    plan.push_back(req_row(ACT_READ, 8'd7, 8'd3, '0, 1'b1, outcome(0, W_A, 0, 0, 16)));
    plan.push_back(req_row(ACT_READ, 8'd3, 8'd7, '0, 1'b0, '0));
    plan.push_back(req_row(ACT_SCAN_START, 8'd7, 8'd0, '0, 1'b1, outcome(0, W_A, 1, 7, 3)));
    plan.push_back(req_row(ACT_SCAN_START, 8'd16, 8'd0, '0, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_NOP6, 8'd255, 8'd255, ALL_ONES, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 0)));
    // Undirected: writes are mirrored and transpose leaves the matrix alone.
    plan.push_back(reg_row(CFG_DIRECTED, 5'd0));
    plan.push_back(req_row(ACT_ADD, 8'd2, 8'd5, W_A, 1'b0, '0));
    plan.push_back(req_row(ACT_READ, 8'd5, 8'd2, '0, 1'b1, outcome(0, W_A, 0, 0, 0)));
    plan.push_back(req_row(ACT_TRANSPOSE, 8'd0, 8'd0, '0, 1'b0, '0));
    // No vertices in use: everything is out of range.
    plan.push_back(reg_row(CFG_VCOUNT, 5'd0));
    plan.push_back(req_row(ACT_ADD, 8'd0, 8'd0, W_A, 1'b1, outcome(1, NO_EDGE, 0, 0, 0)));
    plan.push_back(req_row(ACT_SCAN_START, 8'd0, 8'd0, '0, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 0)));
    // A count above the maximum saturates.
    plan.push_back(reg_row(CFG_VCOUNT, 5'd31));
    plan.push_back(req_row(ACT_SCAN_START, 8'd15, 8'd0, '0, 1'b1,
                           outcome(0, ALL_ONES, 1, 15, 15)));
    // The scan keeps the size it started with after the count shrinks.
    plan.push_back(reg_row(CFG_VCOUNT, 5'd1));
    plan.push_back(req_row(ACT_SCAN_STEP, 8'd0, 8'd0, '0, 1'b1,
                           outcome(0, NO_EDGE, 0, 0, 16)));
    plan.push_back(req_row(ACT_REMOVE, 8'd1, 8'd0, '0, 1'b1, outcome(1, NO_EDGE, 0, 0, 16)));
    plan.push_back(req_row(ACT_REMOVE, 8'd0, 8'd0, '0, 1'b0, '0));

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        issue(plan[k].req, plan[k].pinned, plan[k].result);
      end
    end

    // Random requests under several register settings and idle patterns.
    for (seg = 0; seg < 6; seg++) begin
      drain();
      write_reg(CFG_VCOUNT, seg_vcount[seg]);
      write_reg(CFG_DIRECTED, 5'(seg_dir[seg]));
      for (k = 0; k < int'(ITEMS_PER_SETTING); k++) begin
        hold_off(seg_idle[seg]);
        if ($urandom_range(99) == 0) drain();
        issue(random_request(), 1'b0, '0);
      end
    end

    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left unanswered", 64'(pending_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[weighted_adjacency_matrix_store.f]
+incdir+src
src/wams_pkg.sv
src/wams_seq.sv
src/wams_dp.sv
src/weighted_adjacency_matrix_store.sv
src/wams_checker.sv
test/tb_weighted_adjacency_matrix_store.sv
